>>> rtl/rtd_pkg.sv
package rtd_pkg;

    localparam int WORD_BYTES = 8;
    localparam int BYTE_IDX_W = $clog2(WORD_BYTES);
    localparam logic [15:0] TILE_RESET = 16'd4096;
    localparam logic [16:0] CONS_MAX = 17'h1ffff;
    localparam logic [7:0] COUNT_MASK = 8'h7f;
    localparam logic [7:0] RUN_FLAG = 8'h80;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_LITERAL = 2'd1,
        PH_RUNVAL  = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        CMD_HDR = 2'd0,
        CMD_LIT = 2'd1,
        CMD_RUN = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] data;
        logic [7:0] count;
        logic       last;
    } t_cmd;

endpackage

>>> rtl/rtd_byte_if.sv
interface rtd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

>>> rtl/rtd_word_if.sv
interface rtd_word_if;
    logic        valid;
    logic        ready;
    logic [63:0] word_data;
    logic [3:0]  byte_count;
    logic        tile_end;
    logic [16:0] bytes_consumed;
    logic        overrun;

    modport source (
        output valid, output word_data, output byte_count, output tile_end,
        output bytes_consumed, output overrun, input ready
    );
    modport sink (
        input valid, input word_data, input byte_count, input tile_end,
        input bytes_consumed, input overrun, output ready
    );
endinterface

>>> rtl/rtd_front.sv
module rtd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    rtd_byte_if.sink            i_in,
    input  logic                i_q_full,
    output logic                o_push,
    output rtd_pkg::t_cmd       o_cmd
);

    rtd_pkg::t_phase r_phase, n_phase;
    logic [7:0]      r_left, n_left;
    logic            accept;
    logic [7:0]      left_dec;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && !i_q_full;
    assign o_push     = accept;
    assign left_dec   = (r_left != 8'd0) ? r_left - 8'd1 : 8'd0;

    // next state
    always_comb begin
        n_phase = r_phase;
        n_left  = r_left;
        if (accept) begin
            unique case (r_phase)
                rtd_pkg::PH_LITERAL: begin
                    n_left = left_dec;
                    if (left_dec == 8'd0) begin
                        n_phase = rtd_pkg::PH_HEADER;
                    end
                end
                rtd_pkg::PH_RUNVAL: begin
                    n_phase = rtd_pkg::PH_HEADER;
                    n_left  = 8'd0;
                end
                default: begin
                    n_left  = (i_in.in_byte & rtd_pkg::COUNT_MASK) + 8'd1;
                    n_phase = ((i_in.in_byte & rtd_pkg::RUN_FLAG) != 8'd0) ?
                              rtd_pkg::PH_RUNVAL : rtd_pkg::PH_LITERAL;
                end
            endcase
        end
    end

    // command out
    always_comb begin
        o_cmd.data  = i_in.in_byte;
        o_cmd.count = r_left;
        o_cmd.last  = 1'b0;
        unique case (r_phase)
            rtd_pkg::PH_LITERAL: begin
                o_cmd.kind = rtd_pkg::CMD_LIT;
                o_cmd.last = (left_dec == 8'd0);
            end
            rtd_pkg::PH_RUNVAL: begin
                o_cmd.kind = rtd_pkg::CMD_RUN;
                o_cmd.last = 1'b1;
            end
            default: begin
                o_cmd.kind = rtd_pkg::CMD_HDR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= rtd_pkg::PH_HEADER;
            r_left  <= 8'd0;
        end else begin
            r_phase <= n_phase;
            r_left  <= n_left;
        end
    end

endmodule

>>> rtl/rtd_queue.sv
module rtd_queue #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rtd_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output rtd_pkg::t_cmd o_head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    rtd_pkg::t_cmd    r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

>>> rtl/rtd_back.sv
module rtd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [15:0]   i_cfg_data,
    input  logic          i_cmd_valid,
    input  rtd_pkg::t_cmd i_cmd,
    output logic          o_pop,
    rtd_word_if.source    o_out
);

    localparam int SHIFT_W = rtd_pkg::BYTE_IDX_W + 3;

    logic [15:0] r_tile;
    logic [15:0] r_prod, n_prod;
    logic [16:0] r_cons, n_cons;
    logic [63:0] r_buf, n_buf;
    logic [3:0]  r_fill, n_fill;
    logic        r_ovr, n_ovr;
    logic [7:0]  r_idx, n_idx;

    logic        r_out_valid, n_out_valid;
    logic [63:0] r_out_data, n_out_data;
    logic [3:0]  r_out_cnt, n_out_cnt;
    logic        r_out_end, n_out_end;
    logic [16:0] r_out_cons, n_out_cons;
    logic        r_out_ovr, n_out_ovr;

    logic [15:0] lim;
    logic        step, put, drop, fin, emit_word, emit_last;
    logic [16:0] cons_step;
    logic [63:0] buf_put;
    logic [3:0]  fill_put;
    logic [15:0] prod_put;
    logic [63:0] b1;
    logic [3:0]  f1;
    logic [15:0] p1;
    logic        o1;
    logic [SHIFT_W-1:0] sh;

    assign lim  = (r_tile == 16'd0) ? 16'd1 : r_tile;
    assign step = i_cmd_valid && (!r_out_valid || o_out.ready);
    assign put  = (i_cmd.kind == rtd_pkg::CMD_LIT) || (i_cmd.kind == rtd_pkg::CMD_RUN);
    assign drop = (r_prod >= lim);
    assign sh   = {r_fill[rtd_pkg::BYTE_IDX_W-1:0], 3'b000};

    assign buf_put  = r_buf | ({56'd0, i_cmd.data} << sh);
    assign fill_put = r_fill + 4'd1;
    assign prod_put = r_prod + 16'd1;

    always_comb begin
        cons_step = r_cons;
        if (r_idx == 8'd0 && r_cons != rtd_pkg::CONS_MAX) begin
            cons_step = r_cons + 17'd1;
        end

        case (i_cmd.kind)
            rtd_pkg::CMD_LIT: fin = i_cmd.last;
            rtd_pkg::CMD_RUN: fin = drop || ({1'b0, r_idx} + 9'd1 >= {1'b0, i_cmd.count});
            default:          fin = 1'b0;
        endcase

        b1 = r_buf;
        f1 = r_fill;
        p1 = r_prod;
        o1 = r_ovr;
        emit_word = 1'b0;
        if (put) begin
            if (drop) begin
                o1 = 1'b1;
            end else begin
                b1 = buf_put;
                f1 = fill_put;
                p1 = prod_put;
                emit_word = (fill_put >= 4'(rtd_pkg::WORD_BYTES)) && (prod_put < lim);
            end
        end
        emit_last = fin && (p1 >= lim);

        o_pop = step && (fin || i_cmd.kind != rtd_pkg::CMD_RUN);
    end

    always_comb begin
        n_prod      = r_prod;
        n_cons      = r_cons;
        n_buf       = r_buf;
        n_fill      = r_fill;
        n_ovr       = r_ovr;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_data  = r_out_data;
        n_out_cnt   = r_out_cnt;
        n_out_end   = r_out_end;
        n_out_cons  = r_out_cons;
        n_out_ovr   = r_out_ovr;
        if (step) begin
            n_prod = p1;
            n_cons = cons_step;
            n_buf  = b1;
            n_fill = f1;
            n_ovr  = o1;
            n_idx  = o_pop ? 8'd0 : r_idx + 8'd1;
            if (emit_word || emit_last) begin
                n_out_valid = 1'b1;
                n_out_data  = b1;
                n_out_cnt   = f1;
                n_out_end   = emit_last;
                n_out_cons  = emit_last ? cons_step : 17'd0;
                n_out_ovr   = emit_last && o1;
                n_buf       = 64'd0;
                n_fill      = 4'd0;
            end
            if (emit_last) begin
                n_prod = 16'd0;
                n_cons = 17'd0;
                n_ovr  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile      <= rtd_pkg::TILE_RESET;
            r_prod      <= 16'd0;
            r_cons      <= 17'd0;
            r_buf       <= 64'd0;
            r_fill      <= 4'd0;
            r_ovr       <= 1'b0;
            r_idx       <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tile <= i_cfg_data;
            end
            r_prod      <= n_prod;
            r_cons      <= n_cons;
            r_buf       <= n_buf;
            r_fill      <= n_fill;
            r_ovr       <= n_ovr;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_out_cnt  <= n_out_cnt;
        r_out_end  <= n_out_end;
        r_out_cons <= n_out_cons;
        r_out_ovr  <= n_out_ovr;
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.word_data      = r_out_data;
    assign o_out.byte_count     = r_out_cnt;
    assign o_out.tile_end       = r_out_end;
    assign o_out.bytes_consumed = r_out_cons;
    assign o_out.overrun        = r_out_ovr;

endmodule

>>> rtl/rle_tile_decoder.sv
// a byte is held in the command queue, and the word it completes is then held in the output register
// throughput: one coded byte per cycle for headers and literals; a run holds the back end until all
// its bytes are expanded (or the tile is full), and input stalls when the command queue fills
// the QUEUE_DEPTH-entry command queue lets the byte front end run ahead of the run expansion
// reset: synchronous active-low; clears decode state and queue, the tile size returns to 4096
module rle_tile_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    rtd_byte_if.sink    i_in,
    rtd_word_if.source  o_out
);

    logic          q_full, q_valid, q_pop, f_push;
    rtd_pkg::t_cmd f_cmd, q_head;

    rtd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (f_push),
        .o_cmd    (f_cmd)
    );

    rtd_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_cmd   (f_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    rtd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_head),
        .o_pop       (q_pop),
        .o_out       (o_out)
    );

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int DRAIN_CYCLES = 600;
    localparam int STALL_LIMIT = 5000;
    localparam int ITEMS_PER_BLOCK = 40;
    localparam int NUM_DIR_ROWS = 35;

    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  cnt;
        logic        last;
        logic [16:0] consumed;
        logic        ovr;
    } t_word;

    typedef enum logic {
        ROW_BYTE = 1'b0,
        ROW_CFG  = 1'b1
    } t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [15:0] value;
        logic        typed;
        t_word       exp;
    } t_stim_row;

    localparam t_word NO_WORD = '0;

    localparam t_stim_row DIR_ROWS [NUM_DIR_ROWS] = '{
        '{ROW_CFG,  16'd5,    1'b0, NO_WORD},
        '{ROW_BYTE, 16'h0002, 1'b0, NO_WORD},
        '{ROW_BYTE, 16'h0000, 1'b0, NO_WORD},
        '{ROW_BYTE, 16'h00ff, 1'b0, NO_WORD},
        '{ROW_BYTE, 16'h005a, 1'b0, NO_WORD},
        '{ROW_BYTE, 16'h0081, 1'b0, NO_WORD},
        '{ROW_BYTE, 16'h00a5, 1'b1, '{64'h0000_00a5_a55a_ff00, 4'd5, 1'b1, 17'd6, 1'b0}},
        '{ROW_BYTE, 16'h00ff, 1'b0, NO_WORD},
        '{ROW_BYTE, 16'h003c, 1'b1, '{64'h0000_003c_3c3c_3c3c, 4'd5, 1'b1, 17'd2, 1'b1}},
        '{ROW_BYTE, 16'h0006, 1'b0, NO_WORD},
        '{ROW_BYTE, 16'h0080, 1'b0, NO_WORD},
        '{ROW_BYTE, 16'h007f, 1'b0, NO_WORD},
        '{ROW_BYTE, 16'h0001, 1'b0, NO_WORD},
        '{ROW_BYTE, 16'h00fe, 1'b0, NO_WORD},
        '{ROW_BYTE, 16'h0010, 1'b0, NO_WORD},
        '{ROW_BYTE, 16'h0020, 1'b0, NO_WORD},
        '{ROW_BYTE, 16'h0030, 1'b1, '{64'h0000_0010_fe01_7f80, 4'd5, 1'b1, 17'd8, 1'b1}},
        '{ROW_CFG,  16'd0,    1'b0, NO_WORD},
        '{ROW_BYTE, 16'h0000, 1'b0, NO_WORD},
        '{ROW_BYTE, 16'h0077, 1'b1, '{64'h0000_0000_0000_0077, 4'd1, 1'b1, 17'd2, 1'b0}},
        '{ROW_CFG,  16'd16,   1'b0, NO_WORD},
        '{ROW_BYTE, 16'h008f, 1'b0, NO_WORD},
        '{ROW_BYTE, 16'h00c3, 1'b0, NO_WORD},
        '{ROW_CFG,  16'hffff, 1'b0, NO_WORD},
        '{ROW_BYTE, 16'h0083, 1'b0, NO_WORD},
        '{ROW_BYTE, 16'h0011, 1'b0, NO_WORD},
        '{ROW_CFG,  16'd2,    1'b0, NO_WORD},
        '{ROW_BYTE, 16'h0080, 1'b0, NO_WORD},
        '{ROW_BYTE, 16'h0022, 1'b1, '{64'h0000_0000_1111_1111, 4'd4, 1'b1, 17'd4, 1'b1}},
        '{ROW_CFG,  16'hffff, 1'b0, NO_WORD},
        '{ROW_BYTE, 16'h0087, 1'b0, NO_WORD},
        '{ROW_BYTE, 16'h0044, 1'b0, NO_WORD},
        '{ROW_CFG,  16'd1,    1'b0, NO_WORD},
        '{ROW_BYTE, 16'h0000, 1'b0, NO_WORD},
        '{ROW_BYTE, 16'h0055, 1'b1, '{64'h0, 4'd0, 1'b1, 17'd4, 1'b1}}
    };

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_data;

    rtd_byte_if byte_ch ();
    rtd_word_if word_ch ();

    rle_tile_decoder dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in       (byte_ch.sink),
        .o_out      (word_ch.source)
    );

    int unsigned src_gap_pct;
    int unsigned sink_stall_pct;
    int unsigned n_mismatch;
    int unsigned n_sent;
    int unsigned n_predicted;
    t_word       words_due[$];

    // decoder mirror
    logic [15:0]     tile_size;
    rtd_pkg::t_phase dec_phase;
    int unsigned     run_left;
    int unsigned     produced;
    int unsigned     consumed;
    int unsigned     fill;
    logic [63:0]     pack;
    logic            ovr_seen;

    function automatic void reset_decoder();
        tile_size = rtd_pkg::TILE_RESET;
        dec_phase = rtd_pkg::PH_HEADER;
        run_left = 0;
        produced = 0;
        consumed = 0;
        fill = 0;
        pack = '0;
        ovr_seen = 1'b0;
    endfunction

    function automatic int unsigned tile_limit();
        return (tile_size == 16'd0) ? 1 : tile_size;
    endfunction

    function automatic void flush_word(input logic last);
        t_word w;
        w.data = pack;
        w.cnt = fill[3:0];
        w.last = last;
        w.consumed = last ? consumed[16:0] : 17'd0;
        w.ovr = last & ovr_seen;
        words_due.push_back(w);
        n_predicted++;
        pack = '0;
        fill = 0;
    endfunction

    function automatic void store_byte(input logic [7:0] b);
        if (produced >= tile_limit()) begin
            ovr_seen = 1'b1;
        end else begin
            pack = pack | (64'(b) << (8 * (fill & 7)));
            fill++;
            produced++;
            if (fill >= rtd_pkg::WORD_BYTES && produced < tile_limit()) begin
                flush_word(1'b0);
            end
        end
    endfunction

    function automatic void close_packet();
        dec_phase = rtd_pkg::PH_HEADER;
        run_left = 0;
        if (produced >= tile_limit()) begin
            flush_word(1'b1);
            produced = 0;
            consumed = 0;
            ovr_seen = 1'b0;
        end
    endfunction

    function automatic void decode_byte(input logic [7:0] b);
        if (consumed < rtd_pkg::CONS_MAX) begin
            consumed++;
        end
        case (dec_phase)
            rtd_pkg::PH_LITERAL: begin
                store_byte(b);
                if (run_left > 0) begin
                    run_left--;
                end
                if (run_left == 0) begin
                    close_packet();
                end
            end
            rtd_pkg::PH_RUNVAL: begin
                for (int i = 0; i < run_left; i++) begin
                    store_byte(b);
                end
                close_packet();
            end
            default: begin
                run_left = int'(b & rtd_pkg::COUNT_MASK) + 1;
                dec_phase = ((b & rtd_pkg::RUN_FLAG) != 8'd0) ?
                            rtd_pkg::PH_RUNVAL : rtd_pkg::PH_LITERAL;
            end
        endcase
    endfunction

    function automatic logic [15:0] pick_tile();
        int unsigned r;
        r = $urandom_range(9);
        case (r) inside
            0: return 16'd1;
            1: return 16'hffff;
            [2:6]: return 16'($urandom_range(2, 40));
            default: return 16'($urandom_range(41, 400));
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_gap_pct) begin
            byte_ch.valid <= 1'b0;
            @(posedge clk);
        end
        byte_ch.valid <= 1'b1;
        byte_ch.in_byte <= b;
        @(posedge clk);
        while (!byte_ch.ready) begin
            @(posedge clk);
        end
        decode_byte(b);
        n_sent++;
    endtask

    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        @(posedge clk);
        while (words_due.size() != 0) begin
            @(posedge clk);
        end
    endtask

    task automatic write_tile(input logic [15:0] v);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        tile_size = v;
    endtask

    task automatic send_packet();
        int unsigned pick;
        int unsigned r;
        int unsigned cnt;
        pick = $urandom_range(99);
        r = $urandom_range(99);
        if (r < 70) begin
            cnt = $urandom_range(1, 12);
        end else if (r < 95) begin
            cnt = $urandom_range(13, 64);
        end else begin
            cnt = $urandom_range(65, 128);
        end
        if (pick < 3) begin
            wait_drained();
        end else if (pick < 15) begin
            // noise
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
        end else if ($urandom_range(1) == 1) begin
            send_byte(rtd_pkg::RUN_FLAG | 8'(cnt - 1));
            send_byte(8'($urandom));
        end else begin
            send_byte(8'(cnt - 1));
            repeat (cnt) send_byte(8'($urandom));
        end
    endtask

    task automatic check_word();
        t_word got;
        t_word want;
        got = '{word_ch.word_data, word_ch.byte_count, word_ch.tile_end,
                word_ch.bytes_consumed, word_ch.overrun};
        if (words_due.size() == 0) begin
            n_mismatch++;
            if (n_mismatch <= 10) begin
                $display("unexpected word: data %h count %0d end %b consumed %0d overrun %b",
                         got.data, got.cnt, got.last, got.consumed, got.ovr);
            end
        end else begin
            want = words_due.pop_front();
            if (got.data !== want.data || got.cnt !== want.cnt || got.last !== want.last ||
                got.consumed !== want.consumed || got.ovr !== want.ovr) begin
                n_mismatch++;
                if (n_mismatch <= 10) begin
                    $display("word mismatch (exp/got): data %h/%h count %0d/%0d end %b/%b",
                             want.data, got.data, want.cnt, got.cnt, want.last, got.last);
                    $display("    consumed %0d/%0d overrun %b/%b",
                             want.consumed, got.consumed, want.ovr, got.ovr);
                end
            end
        end
    endtask

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        word_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        if (rst_n && word_ch.valid && word_ch.ready) begin
            check_word();
        end
    end

    initial begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((byte_ch.valid && byte_ch.ready) || (word_ch.valid && word_ch.ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("FAILURE");
        $finish;
    end

    initial begin
        t_stim_row   row;
        int unsigned pred_before;
        int unsigned blk_start;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_data <= '0;
        byte_ch.valid <= 1'b0;
        byte_ch.in_byte <= '0;
        n_mismatch = 0;
        n_sent = 0;
        n_predicted = 0;
        src_gap_pct = 24;
        sink_stall_pct = 49;
        reset_decoder();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // one full tile at the reset tile size, longest runs
        repeat (32) begin
            send_byte(rtd_pkg::RUN_FLAG | rtd_pkg::COUNT_MASK);
            send_byte(8'($urandom));
        end

        for (int i = 0; i < NUM_DIR_ROWS; i++) begin
            row = DIR_ROWS[i];
            if (row.kind == ROW_CFG) begin
                write_tile(row.value);
            end else begin
                pred_before = n_predicted;
                send_byte(row.value[7:0]);
                if (row.typed) begin
                    repeat (n_predicted - pred_before) void'(words_due.pop_back());
                    words_due.push_back(row.exp);
                end
            end
        end

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    src_gap_pct = 24;
                    sink_stall_pct = 49;
                end
                1: begin
                    src_gap_pct = 49;
                    sink_stall_pct = 24;
                end
                default: begin
                    src_gap_pct = 0;
                    sink_stall_pct = 0;
                end
            endcase
            repeat (3) begin
                write_tile(pick_tile());
                blk_start = n_sent;
                while (n_sent - blk_start < ITEMS_PER_BLOCK) begin
                    send_packet();
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (n_mismatch == 0 && words_due.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
